>>> sv/cspt_pkg.sv
// Shared types, constants and register codes for the cylinder support point block.
`timescale 1ns / 1ps

package cspt_pkg;

    localparam int RING_POINTS_DEF = 20;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_X    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CENTER_Z    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_X      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_Y      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_AXIS_Z      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_HEIGHT = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_PERP_THRESH = 3'd7;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               command;
        logic [5:0]         point_index;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] support_x;
        logic signed [31:0] support_y;
        logic signed [31:0] support_z;
        logic               from_cap;
        logic [5:0]         rim_slot;
    } res_t;

    typedef struct packed {
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic signed [17:0] axis_x;
        logic signed [17:0] axis_y;
        logic signed [17:0] axis_z;
        logic [30:0]        half_height;
        logic [31:0]        perp_threshold;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        center_x:       32'sd0,
        center_y:       32'sd0,
        center_z:       32'sd0,
        axis_x:         18'sd0,
        axis_y:         18'sd65536,
        axis_z:         18'sd0,
        half_height:    31'd65536,
        perp_threshold: 32'd43
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec3_t;

    // Axis test outcome: done, ring side, rim versus cap, and the cap centre
    typedef struct packed {
        logic               done;
        logic               up;
        logic               big;
        logic signed [31:0] cap_x;
        logic signed [31:0] cap_y;
        logic signed [31:0] cap_z;
    } axis_res_t;

    // Marks travelling with each rim point read during a scan
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } scan_tag_t;

endpackage

>>> sv/cspt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module cspt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/cspt_axis.sv
// Axis test pipeline: ring side, perpendicular length check and cap centre.
`timescale 1ns / 1ps

module cspt_axis
    import cspt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  vec3_t     dir,
    input  cfg_t      cfg,
    output axis_res_t res
);

    localparam logic signed [34:0] SAT_HI = 35'sd2147483647;
    localparam logic signed [34:0] SAT_LO = -35'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > SAT_HI)
            r = SAT_HI[31:0];
        else if (v < SAT_LO)
            r = SAT_LO[31:0];
        else
            r = v[31:0];
        return r;
    endfunction

    logic [4:0] v_reg;
    logic       done_reg;

    // Stage 1
    logic signed [49:0] dax_x, dax_y, dax_z;
    logic signed [49:0] dax_x_reg, dax_y_reg, dax_z_reg;
    logic signed [31:0] hh_s;
    logic signed [49:0] hprod_x, hprod_y, hprod_z;
    logic signed [33:0] off_x_reg, off_y_reg, off_z_reg;
    // Stage 2
    logic signed [51:0] dt_sum;
    logic               up_reg;
    logic signed [35:0] t_reg;
    logic signed [31:0] cap_p_x_reg, cap_p_y_reg, cap_p_z_reg;
    logic signed [31:0] cap_m_x_reg, cap_m_y_reg, cap_m_z_reg;
    // Stage 3
    logic signed [53:0] tprod_x, tprod_y, tprod_z;
    logic signed [53:0] tax_x_reg, tax_y_reg, tax_z_reg;
    // Stage 4
    logic signed [38:0] pd_x, pd_y, pd_z;
    logic [38:0]        mag_x, mag_y, mag_z;
    logic [15:0]        m_x_reg, m_y_reg, m_z_reg;
    logic               bigc_reg;
    // Stage 5
    logic [31:0]        sq_x_reg, sq_y_reg, sq_z_reg;
    logic               bigs_reg;
    // Stage 6
    logic [33:0]        sq_sum;
    logic               big_reg;

    always_comb
    begin
        hh_s    = $signed({1'b0, cfg.half_height});
        dax_x   = dir.x * cfg.axis_x;
        dax_y   = dir.y * cfg.axis_y;
        dax_z   = dir.z * cfg.axis_z;
        hprod_x = cfg.axis_x * hh_s;
        hprod_y = cfg.axis_y * hh_s;
        hprod_z = cfg.axis_z * hh_s;
        dt_sum  = 52'(dax_x_reg) + 52'(dax_y_reg) + 52'(dax_z_reg);
        tprod_x = t_reg * cfg.axis_x;
        tprod_y = t_reg * cfg.axis_y;
        tprod_z = t_reg * cfg.axis_z;
        pd_x    = 39'(dir.x) - 39'(tax_x_reg >>> 16);
        pd_y    = 39'(dir.y) - 39'(tax_y_reg >>> 16);
        pd_z    = 39'(dir.z) - 39'(tax_z_reg >>> 16);
        mag_x   = pd_x[38] ? 39'(-pd_x) : 39'(pd_x);
        mag_y   = pd_y[38] ? 39'(-pd_y) : 39'(pd_y);
        mag_z   = pd_z[38] ? 39'(-pd_z) : 39'(pd_z);
        sq_sum  = 34'(sq_x_reg) + 34'(sq_y_reg) + 34'(sq_z_reg);
    end

    // Datapath runs every cycle; user must hold inputs per query, unchecked
    always_ff @(posedge clk)
    begin
        dax_x_reg   <= dax_x;
        dax_y_reg   <= dax_y;
        dax_z_reg   <= dax_z;
        off_x_reg   <= 34'(hprod_x >>> 16);
        off_y_reg   <= 34'(hprod_y >>> 16);
        off_z_reg   <= 34'(hprod_z >>> 16);

        up_reg      <= !dt_sum[51];
        t_reg       <= 36'(dt_sum >>> 16);
        cap_p_x_reg <= sat32(35'(cfg.center_x) + 35'(off_x_reg));
        cap_p_y_reg <= sat32(35'(cfg.center_y) + 35'(off_y_reg));
        cap_p_z_reg <= sat32(35'(cfg.center_z) + 35'(off_z_reg));
        cap_m_x_reg <= sat32(35'(cfg.center_x) - 35'(off_x_reg));
        cap_m_y_reg <= sat32(35'(cfg.center_y) - 35'(off_y_reg));
        cap_m_z_reg <= sat32(35'(cfg.center_z) - 35'(off_z_reg));

        tax_x_reg   <= tprod_x;
        tax_y_reg   <= tprod_y;
        tax_z_reg   <= tprod_z;

        // Any component of magnitude 1.0 or more exceeds every threshold
        m_x_reg     <= mag_x[15:0];
        m_y_reg     <= mag_y[15:0];
        m_z_reg     <= mag_z[15:0];
        bigc_reg    <= (|mag_x[38:16]) || (|mag_y[38:16]) || (|mag_z[38:16]);

        sq_x_reg    <= m_x_reg * m_x_reg;
        sq_y_reg    <= m_y_reg * m_y_reg;
        sq_z_reg    <= m_z_reg * m_z_reg;
        bigs_reg    <= bigc_reg;

        big_reg     <= bigs_reg || (sq_sum > 34'(cfg.perp_threshold));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg    <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            v_reg <= {v_reg[3:0], start};
            if (start)
                done_reg <= 1'b0;
            else if (v_reg[4])
                done_reg <= 1'b1;
        end
    end

    always_comb
    begin
        res.done  = done_reg;
        res.up    = up_reg;
        res.big   = big_reg;
        res.cap_x = up_reg ? cap_p_x_reg : cap_m_x_reg;
        res.cap_y = up_reg ? cap_p_y_reg : cap_m_y_reg;
        res.cap_z = up_reg ? cap_p_z_reg : cap_m_z_reg;
    end

endmodule

>>> sv/cspt_dot.sv
// Dot product and running maximum over the rim points streamed from memory.
`timescale 1ns / 1ps

module cspt_dot
    import cspt_pkg::*;
#(
    parameter int RING_POINTS = RING_POINTS_DEF,
    localparam int SLOT_W = $clog2(2 * RING_POINTS)
)(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clear,
    input  scan_tag_t          tag,
    input  logic [SLOT_W-1:0]  idx,
    input  vec3_t              pnt,
    input  vec3_t              dir,
    output logic               done,
    output logic [SLOT_W-1:0]  best
);

    scan_tag_t          tag_p_reg, tag_s_reg;
    logic [SLOT_W-1:0]  idx_p_reg, idx_s_reg;
    logic signed [63:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [63:0] prod_x, prod_y, prod_z;
    logic signed [65:0] sum_reg;
    logic signed [65:0] best_sum_reg;
    logic [SLOT_W-1:0]  best_reg;
    logic               done_reg;
    logic               take;

    always_comb
    begin
        prod_x = pnt.x * dir.x;
        prod_y = pnt.y * dir.y;
        prod_z = pnt.z * dir.z;
        // Strictly greater keeps the first point on ties
        take   = tag_s_reg.valid && (tag_s_reg.first || (sum_reg > best_sum_reg));
    end

    always_ff @(posedge clk)
    begin
        prod_x_reg <= prod_x;
        prod_y_reg <= prod_y;
        prod_z_reg <= prod_z;
        idx_p_reg  <= idx;
        sum_reg    <= 66'(prod_x_reg) + 66'(prod_y_reg) + 66'(prod_z_reg);
        idx_s_reg  <= idx_p_reg;
        if (take)
        begin
            best_sum_reg <= sum_reg;
            best_reg     <= idx_s_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_p_reg <= '0;
            tag_s_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            tag_p_reg <= tag;
            tag_s_reg <= tag_p_reg;
            if (clear)
                done_reg <= 1'b0;
            else if (tag_s_reg.valid && tag_s_reg.last)
                done_reg <= 1'b1;
        end
    end

    assign done = done_reg;
    assign best = best_reg;

    a_best_in_top_ring: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (int'(best_reg) < RING_POINTS))
        else $error("chosen rim slot outside the top ring");

    a_first_is_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (tag_p_reg.valid && tag_p_reg.first) |-> (idx_p_reg == '0))
        else $error("scan start mark not on slot zero");

endmodule

>>> sv/cylinder_support_point_core.sv
// Top level of the cylinder support point block: memory, sequencer and output register.
//
// Channels: cmd (cmd_valid/cmd_ready, cmd_t) takes load and query transactions;
// res (res_valid/res_ready, res_t) returns one transaction per query, none per load.
// cfg_write/cfg_index/cfg_data write a configuration register.
// A load writes one rim slot of the point memory;
// a slot index at or above 2*RING_POINTS is dropped.
// A query streams the RING_POINTS top-ring points from the memory, one read per
// cycle, through a dot product and running-maximum pipeline, while the axis test
// runs alongside. A rim answer adds one more memory read for the chosen ring.
// Query time is set by the single memory read port walking the ring; a rim answer
// passes WAIT, FETCH and EMIT, a cap answer WAIT and EMIT. The next transaction
// is taken once the answer has been moved to the output register, so queries do
// not overlap.
// cmd_ready is high only between queries; loads go back to back.
// A finished result sits in the output register; a new item is accepted while it
// waits, and a following query holds its answer until res_ready frees the register.
// Reset restores the configuration defaults and empties the output; the point
// memory is not cleared and must be loaded before it is queried.
`timescale 1ns / 1ps

module cylinder_support_point_core
    import cspt_pkg::*;
#(
    parameter int RING_POINTS = RING_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  cmd_t                   cmd,
    output logic                   res_valid,
    input  logic                   res_ready,
    output res_t                   res,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOTS  = 2 * RING_POINTS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int MEM_W  = 3 * COORD_WIDTH;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_WAIT  = 5'b00100,
        ST_FETCH = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    cfg_t              cfg_reg;
    vec3_t             dir_reg;
    logic [SLOT_W-1:0] scan_idx_reg, scan_idx_next;
    logic [SLOT_W-1:0] fin_idx_reg;
    scan_tag_t         rd_tag_reg, rd_tag_next;
    logic [SLOT_W-1:0] rd_idx_reg;
    res_t              pend_reg;
    res_t              res_reg;
    logic              res_valid_reg;

    logic              accept;
    logic              is_query;
    logic              scan_last;
    logic              both_done;
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [MEM_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [SLOT_W-1:0] ram_raddr;
    logic [MEM_W-1:0]  ram_rdata;
    logic [SLOT_W-1:0] final_addr;
    logic              axis_start;
    logic              out_load;
    axis_res_t         axis_res;
    logic              dot_done;
    logic [SLOT_W-1:0] dot_best;

    logic signed [COORD_WIDTH-1:0] rd_x, rd_y, rd_z;
    vec3_t             rd_pnt;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;
    assign is_query  = (cmd.command == CMD_QUERY);
    assign scan_last = (scan_idx_reg == SLOT_W'(RING_POINTS - 1));
    assign both_done = dot_done && axis_res.done;
    assign out_load  = (state_reg == ST_EMIT) && (!res_valid_reg || res_ready);

    // Loads write memory only while no query is in flight
    assign ram_we    = accept && !is_query && (int'(cmd.point_index) < SLOTS);
    assign ram_waddr = SLOT_W'(cmd.point_index);
    assign ram_wdata = {cmd.vec_z[COORD_WIDTH-1:0], cmd.vec_y[COORD_WIDTH-1:0],
                        cmd.vec_x[COORD_WIDTH-1:0]};

    assign final_addr = axis_res.up ? dot_best : (dot_best + SLOT_W'(RING_POINTS));
    assign axis_start = (state_reg == ST_SCAN) && (scan_idx_reg == '0);

    always_comb
    begin
        rd_x     = ram_rdata[COORD_WIDTH-1:0];
        rd_y     = ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
        rd_z     = ram_rdata[3*COORD_WIDTH-1:2*COORD_WIDTH];
        rd_pnt.x = 32'(rd_x);
        rd_pnt.y = 32'(rd_y);
        rd_pnt.z = 32'(rd_z);
    end

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        rd_tag_next   = '0;
        ram_re        = 1'b0;
        ram_raddr     = scan_idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                scan_idx_next = '0;
                if (accept && is_query)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                ram_re            = 1'b1;
                rd_tag_next.valid = 1'b1;
                rd_tag_next.first = (scan_idx_reg == '0);
                rd_tag_next.last  = scan_last;
                scan_idx_next     = scan_idx_reg + SLOT_W'(1);
                if (scan_last)
                    state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (both_done)
                begin
                    if (axis_res.big)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = final_addr;
                        state_next = ST_FETCH;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FETCH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            rd_tag_reg    <= '0;
            res_valid_reg <= 1'b0;
            cfg_reg       <= CFG_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            rd_tag_reg   <= rd_tag_next;
            if (out_load)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    CFG_CENTER_X:    cfg_reg.center_x       <= cfg_data;
                    CFG_CENTER_Y:    cfg_reg.center_y       <= cfg_data;
                    CFG_CENTER_Z:    cfg_reg.center_z       <= cfg_data;
                    CFG_AXIS_X:      cfg_reg.axis_x         <= cfg_data[17:0];
                    CFG_AXIS_Y:      cfg_reg.axis_y         <= cfg_data[17:0];
                    CFG_AXIS_Z:      cfg_reg.axis_z         <= cfg_data[17:0];
                    CFG_HALF_HEIGHT: cfg_reg.half_height    <= cfg_data[30:0];
                    CFG_PERP_THRESH: cfg_reg.perp_threshold <= cfg_data;
                    default:         ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_query)
        begin
            dir_reg.x <= cmd.vec_x;
            dir_reg.y <= cmd.vec_y;
            dir_reg.z <= cmd.vec_z;
        end
        rd_idx_reg <= scan_idx_reg;
        if ((state_reg == ST_WAIT) && both_done)
        begin
            fin_idx_reg <= final_addr;
            // Cap answer is complete here; a rim answer is filled in by the fetch
            pend_reg.support_x <= axis_res.cap_x;
            pend_reg.support_y <= axis_res.cap_y;
            pend_reg.support_z <= axis_res.cap_z;
            pend_reg.from_cap  <= 1'b1;
            pend_reg.rim_slot  <= '0;
        end
        if (state_reg == ST_FETCH)
        begin
            pend_reg.support_x <= rd_pnt.x;
            pend_reg.support_y <= rd_pnt.y;
            pend_reg.support_z <= rd_pnt.z;
            pend_reg.from_cap  <= 1'b0;
            pend_reg.rim_slot  <= 6'(fin_idx_reg);
        end
        if (out_load)
            res_reg <= pend_reg;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    cspt_ram #(
        .WIDTH (MEM_W),
        .DEPTH (SLOTS)
    ) u_rim_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    cspt_axis u_axis (
        .clk   (clk),
        .rst_n (rst_n),
        .start (axis_start),
        .dir   (dir_reg),
        .cfg   (cfg_reg),
        .res   (axis_res)
    );

    cspt_dot #(
        .RING_POINTS (RING_POINTS)
    ) u_dot (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (axis_start),
        .tag   (rd_tag_reg),
        .idx   (rd_idx_reg),
        .pnt   (rd_pnt),
        .dir   (dir_reg),
        .done  (dot_done),
        .best  (dot_best)
    );

    a_cap_has_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.from_cap) |-> (res.rim_slot == '0))
        else $error("cap answer carries a rim slot");

    a_fetch_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> ($past(state_reg) == ST_WAIT))
        else $error("final rim read without a finished scan");

    a_leave_wait_when_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WAIT) && (state_next != ST_WAIT)) |-> (dot_done && axis_res.done))
        else $error("query resolved before scan and axis test finished");

endmodule
